FILE: sv/assert_macros.svh
// assertion macros used by the fft controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: sv/r2fft_pkg.sv
// shared types, constants and twiddle functions of the radix-2 fft
package r2fft_pkg;

	localparam int MAX_POINTS_DEF   = 64;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int IDX_W            = 7;
	localparam int LG_W             = 3;
	localparam logic [LG_W-1:0] LOG2_POINTS_RST = 3'd6;

	typedef enum logic [0:0] {
		REG_LOG2_POINTS,
		REG_INVERSE_MODE
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_SUM,
		ST_BF_WA,
		ST_BF_WB,
		ST_OUT_RD,
		ST_OUT_LD
	} ctl_state_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_LOAD,
		DP_COPY_RD,
		DP_COPY_WR,
		DP_BF_RD,
		DP_BF_MUL,
		DP_BF_SUM,
		DP_BF_WA,
		DP_BF_WB,
		DP_OUT_RD,
		DP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [IDX_W-1:0]  idx;
		logic [LG_W-1:0]   stage;
		logic [LG_W-1:0]   lg;
		logic              inverse;
		logic              fill;
		logic              trunc;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

	function automatic int largest_log2(input int mp);
		int l;
		l = 1;
		for (int i = 0; i < 5; i++) begin
			if (l < 6 && (2 << l) <= mp) begin
				l = l + 1;
			end
		end
		return l;
	endfunction

	// cos(2*pi*k/64) in q1.14 for k = 0..16
	function automatic logic signed [15:0] quarter_cos(input logic [4:0] k);
		logic signed [15:0] v;
		unique case (k)
			5'd0:    v = 16'sd16384;
			5'd1:    v = 16'sd16305;
			5'd2:    v = 16'sd16069;
			5'd3:    v = 16'sd15679;
			5'd4:    v = 16'sd15137;
			5'd5:    v = 16'sd14449;
			5'd6:    v = 16'sd13623;
			5'd7:    v = 16'sd12665;
			5'd8:    v = 16'sd11585;
			5'd9:    v = 16'sd10394;
			5'd10:   v = 16'sd9102;
			5'd11:   v = 16'sd7723;
			5'd12:   v = 16'sd6270;
			5'd13:   v = 16'sd4756;
			5'd14:   v = 16'sd3196;
			5'd15:   v = 16'sd1606;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] tw_cos(input logic [4:0] k);
		logic [5:0] m;
		m = 6'd32 - {1'b0, k};
		return (k <= 5'd16) ? quarter_cos(k) : -quarter_cos(m[4:0]);
	endfunction

	function automatic logic signed [15:0] tw_sin(input logic [4:0] k);
		return (k <= 5'd16) ? quarter_cos(5'd16 - k) : quarter_cos(k - 5'd16);
	endfunction

	function automatic logic [5:0] bit_rev6(input logic [5:0] i);
		logic [5:0] r;
		for (int b = 0; b < 6; b++) begin
			r[b] = i[5-b];
		end
		return r;
	endfunction

endpackage

FILE: sv/r2fft_ram.sv
// generic ram, one write port and two registered read ports
module r2fft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

FILE: sv/r2fft_dp.sv
// fft datapath: sample and work memories, butterfly unit, output register
module r2fft_dp #(
	parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  r2fft_pkg::cmd_t                cmd,
	output r2fft_pkg::status_t             status,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH+6:0] bin_re,
	output logic signed [SAMPLE_WIDTH+6:0] bin_im,
	output logic [5:0]                     bin_index,
	output logic                           bin_last,
	output logic                           truncated
);

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int ACC_W = SAMPLE_WIDTH + 7;
	localparam int P_W   = ACC_W + 16;
	localparam int S_W   = P_W + 1;
	localparam int T_W   = ACC_W + 2;
	localparam int X_W   = T_W + 1;
	localparam int IDX_W_L = r2fft_pkg::IDX_W;
	localparam logic signed [X_W-1:0] SAT_HI = X_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
	localparam logic signed [X_W-1:0] SAT_LO = X_W'(-(64'sd1 <<< (ACC_W - 1)));

	logic [2*SAMPLE_WIDTH-1:0] smp_rd;
	logic [2*ACC_W-1:0]        wk_rd_a, wk_rd_b, wk_wr_data;
	logic                      wk_we, smp_we, bf_phase;
	logic [AW-1:0]             wk_wr_addr, wk_rd_addr_a, wk_rd_addr_b;
	logic [IDX_W_L-1:0]        lowmask, idx_a, idx_b, half7, rev7;
	logic [4:0]                tw_k;
	logic signed [15:0]        tw_c, tw_s;
	logic signed [ACC_W-1:0]   b_re, b_im, a_re, a_im, smp_re_x, smp_im_x, sat_p_re, sat_p_im;
	logic signed [ACC_W-1:0]   sat_m_re, sat_m_im;
	logic signed [SAMPLE_WIDTH-1:0] smp_re, smp_im;

	logic signed [ACC_W-1:0]   a_re_s1, a_im_s1;
	logic signed [P_W-1:0]     p_rc_s1, p_is_s1, p_ic_s1, p_rs_s1;
	logic signed [T_W-1:0]     t_re_s2, t_im_s2;
	logic signed [S_W-1:0]     sum_re, sum_im;
	logic                      out_valid_q;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [X_W-1:0] x);
		if (x > SAT_HI) begin
			return SAT_HI[ACC_W-1:0];
		end else if (x < SAT_LO) begin
			return SAT_LO[ACC_W-1:0];
		end
		return x[ACC_W-1:0];
	endfunction

	// butterfly addressing: insert a zero bit at position stage-1
	always_comb begin
		lowmask = (IDX_W_L'(1) << (cmd.stage - 3'd1)) - IDX_W_L'(1);
		half7   = IDX_W_L'(1) << (cmd.stage - 3'd1);
		idx_a   = ((cmd.idx & ~lowmask) << 1) | (cmd.idx & lowmask);
		idx_b   = idx_a | half7;
		tw_k    = 5'((cmd.idx & lowmask) << (3'd6 - cmd.stage));
		tw_c    = r2fft_pkg::tw_cos(tw_k);
		tw_s    = r2fft_pkg::tw_sin(tw_k);
		rev7    = IDX_W_L'(r2fft_pkg::bit_rev6(cmd.idx[5:0]) >> (3'd6 - cmd.lg));
	end

	assign bf_phase = (cmd.op == r2fft_pkg::DP_BF_RD) || (cmd.op == r2fft_pkg::DP_BF_MUL) ||
	                  (cmd.op == r2fft_pkg::DP_BF_SUM) || (cmd.op == r2fft_pkg::DP_BF_WA) ||
	                  (cmd.op == r2fft_pkg::DP_BF_WB);
	assign smp_we = (cmd.op == r2fft_pkg::DP_LOAD);

	r2fft_ram #(.WIDTH(2 * SAMPLE_WIDTH), .DEPTH(MAX_POINTS)) u_smp_ram (
		.clk       (clk),
		.we        (smp_we),
		.wr_addr   (cmd.idx[AW-1:0]),
		.wr_data   ({sample_re, sample_im}),
		.rd_addr_a (cmd.idx[AW-1:0]),
		.rd_addr_b (cmd.idx[AW-1:0]),
		.rd_data_a (smp_rd),
		.rd_data_b ()
	);

	assign smp_re   = smp_rd[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
	assign smp_im   = smp_rd[SAMPLE_WIDTH-1:0];
	assign smp_re_x = cmd.fill ? ACC_W'(smp_re) : '0;
	assign smp_im_x = (cmd.fill && cmd.inverse) ? -ACC_W'(smp_im) : '0;

	assign b_re = wk_rd_b[2*ACC_W-1:ACC_W];
	assign b_im = wk_rd_b[ACC_W-1:0];
	assign a_re = wk_rd_a[2*ACC_W-1:ACC_W];
	assign a_im = wk_rd_a[ACC_W-1:0];

	assign sat_p_re = sat_acc(X_W'(a_re_s1) + X_W'(t_re_s2));
	assign sat_p_im = sat_acc(X_W'(a_im_s1) + X_W'(t_im_s2));
	assign sat_m_re = sat_acc(X_W'(a_re_s1) - X_W'(t_re_s2));
	assign sat_m_im = sat_acc(X_W'(a_im_s1) - X_W'(t_im_s2));

	always_comb begin
		wk_we        = 1'b0;
		wk_wr_addr   = rev7[AW-1:0];
		wk_wr_data   = {smp_re_x, smp_im_x};
		wk_rd_addr_a = bf_phase ? idx_a[AW-1:0] : cmd.idx[AW-1:0];
		wk_rd_addr_b = idx_b[AW-1:0];
		unique case (cmd.op)
			r2fft_pkg::DP_COPY_WR: begin
				wk_we = 1'b1;
			end
			r2fft_pkg::DP_BF_WA: begin
				wk_we      = 1'b1;
				wk_wr_addr = idx_a[AW-1:0];
				wk_wr_data = {sat_p_re, sat_p_im};
			end
			r2fft_pkg::DP_BF_WB: begin
				wk_we      = 1'b1;
				wk_wr_addr = idx_b[AW-1:0];
				wk_wr_data = {sat_m_re, sat_m_im};
			end
			default: begin
				wk_we = 1'b0;
			end
		endcase
	end

	r2fft_ram #(.WIDTH(2 * ACC_W), .DEPTH(MAX_POINTS)) u_work_ram (
		.clk       (clk),
		.we        (wk_we),
		.wr_addr   (wk_wr_addr),
		.wr_data   (wk_wr_data),
		.rd_addr_a (wk_rd_addr_a),
		.rd_addr_b (wk_rd_addr_b),
		.rd_data_a (wk_rd_a),
		.rd_data_b (wk_rd_b)
	);

	// products, then rounded twiddle product
	always_ff @(posedge clk) begin
		if (cmd.op == r2fft_pkg::DP_BF_MUL) begin
			a_re_s1 <= a_re;
			a_im_s1 <= a_im;
			p_rc_s1 <= P_W'(b_re) * P_W'(tw_c);
			p_is_s1 <= P_W'(b_im) * P_W'(tw_s);
			p_ic_s1 <= P_W'(b_im) * P_W'(tw_c);
			p_rs_s1 <= P_W'(b_re) * P_W'(tw_s);
		end
		if (cmd.op == r2fft_pkg::DP_BF_SUM) begin
			t_re_s2 <= T_W'((sum_re + S_W'(8192)) >>> 14);
			t_im_s2 <= T_W'((sum_im + S_W'(8192)) >>> 14);
		end
	end

	assign sum_re = S_W'(p_rc_s1) + S_W'(p_is_s1);
	assign sum_im = S_W'(p_ic_s1) - S_W'(p_rs_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == r2fft_pkg::DP_OUT_LOAD) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == r2fft_pkg::DP_OUT_LOAD) begin
			bin_re    <= a_re;
			bin_im    <= cmd.inverse ? '0 : a_im;
			bin_index <= cmd.idx[5:0];
			bin_last  <= cmd.last;
			truncated <= cmd.trunc;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

FILE: sv/r2fft_ctrl.sv
// fft controller: config registers, frame counters and sequencing state machine
`include "assert_macros.svh"
module r2fft_ctrl #(
	parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [2:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               frame_last,
	input  r2fft_pkg::status_t status,
	output r2fft_pkg::cmd_t    cmd
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [2:0] LG_MAX = 3'(r2fft_pkg::largest_log2(MAX_POINTS));
	localparam int IW = r2fft_pkg::IDX_W;

	r2fft_pkg::ctl_state_t state_q, state_d;
	logic [2:0]    log2_q, lg_act, stage_q;
	logic          inv_q, trunc_q, accept, room;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q, n7, half7;
	logic          idx_last, bf_last, frame_done;

	always_comb begin
		if (log2_q == 3'd0) begin
			lg_act = 3'd1;
		end else if (log2_q > LG_MAX) begin
			lg_act = LG_MAX;
		end else begin
			lg_act = log2_q;
		end
	end

	assign n7         = IW'(1) << lg_act;
	assign half7      = n7 >> 1;
	assign accept     = in_valid && (state_q == r2fft_pkg::ST_IDLE);
	assign room       = IW'(count_q) < n7;
	assign idx_last   = (idx_q == n7 - IW'(1));
	assign bf_last    = (idx_q == half7 - IW'(1));
	assign frame_done = (state_q == r2fft_pkg::ST_OUT_LD) && status.out_free && idx_last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			r2fft_pkg::ST_IDLE:    if (accept && frame_last) state_d = r2fft_pkg::ST_COPY_RD;
			r2fft_pkg::ST_COPY_RD: state_d = r2fft_pkg::ST_COPY_WR;
			r2fft_pkg::ST_COPY_WR: state_d = idx_last ? r2fft_pkg::ST_BF_RD : r2fft_pkg::ST_COPY_RD;
			r2fft_pkg::ST_BF_RD:   state_d = r2fft_pkg::ST_BF_MUL;
			r2fft_pkg::ST_BF_MUL:  state_d = r2fft_pkg::ST_BF_SUM;
			r2fft_pkg::ST_BF_SUM:  state_d = r2fft_pkg::ST_BF_WA;
			r2fft_pkg::ST_BF_WA:   state_d = r2fft_pkg::ST_BF_WB;
			r2fft_pkg::ST_BF_WB: begin
				state_d = (bf_last && stage_q == lg_act) ? r2fft_pkg::ST_OUT_RD
				                                         : r2fft_pkg::ST_BF_RD;
			end
			r2fft_pkg::ST_OUT_RD:  state_d = r2fft_pkg::ST_OUT_LD;
			r2fft_pkg::ST_OUT_LD: begin
				if (status.out_free) begin
					state_d = idx_last ? r2fft_pkg::ST_IDLE : r2fft_pkg::ST_OUT_RD;
				end
			end
			default:               state_d = r2fft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.op      = r2fft_pkg::DP_NONE;
		cmd.idx     = idx_q;
		cmd.stage   = stage_q;
		cmd.lg      = lg_act;
		cmd.inverse = inv_q;
		cmd.fill    = idx_q < IW'(count_q);
		cmd.trunc   = trunc_q;
		cmd.last    = idx_last;
		in_stall    = (state_q != r2fft_pkg::ST_IDLE);
		unique case (state_q)
			r2fft_pkg::ST_IDLE: begin
				cmd.idx = IW'(count_q);
				if (accept && room) cmd.op = r2fft_pkg::DP_LOAD;
			end
			r2fft_pkg::ST_COPY_RD: cmd.op = r2fft_pkg::DP_COPY_RD;
			r2fft_pkg::ST_COPY_WR: cmd.op = r2fft_pkg::DP_COPY_WR;
			r2fft_pkg::ST_BF_RD:   cmd.op = r2fft_pkg::DP_BF_RD;
			r2fft_pkg::ST_BF_MUL:  cmd.op = r2fft_pkg::DP_BF_MUL;
			r2fft_pkg::ST_BF_SUM:  cmd.op = r2fft_pkg::DP_BF_SUM;
			r2fft_pkg::ST_BF_WA:   cmd.op = r2fft_pkg::DP_BF_WA;
			r2fft_pkg::ST_BF_WB:   cmd.op = r2fft_pkg::DP_BF_WB;
			r2fft_pkg::ST_OUT_RD:  cmd.op = r2fft_pkg::DP_OUT_RD;
			r2fft_pkg::ST_OUT_LD: begin
				cmd.op = status.out_free ? r2fft_pkg::DP_OUT_LOAD : r2fft_pkg::DP_OUT_RD;
			end
			default:               cmd.op = r2fft_pkg::DP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= r2fft_pkg::ST_IDLE;
			log2_q  <= r2fft_pkg::LOG2_POINTS_RST;
			inv_q   <= 1'b0;
			count_q <= '0;
			trunc_q <= 1'b0;
			idx_q   <= '0;
			stage_q <= 3'd1;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (r2fft_pkg::cfg_reg_t'(cfg_index))
					r2fft_pkg::REG_LOG2_POINTS:  log2_q <= cfg_data;
					r2fft_pkg::REG_INVERSE_MODE: inv_q  <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				r2fft_pkg::ST_IDLE: begin
					if (accept) begin
						if (room) count_q <= count_q + CW'(1);
						else      trunc_q <= 1'b1;
					end
					idx_q   <= '0;
					stage_q <= 3'd1;
				end
				r2fft_pkg::ST_COPY_WR: idx_q <= idx_last ? '0 : idx_q + IW'(1);
				r2fft_pkg::ST_BF_WB: begin
					if (bf_last) begin
						idx_q   <= '0;
						stage_q <= stage_q + 3'd1;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				r2fft_pkg::ST_OUT_LD: begin
					if (status.out_free) begin
						idx_q <= idx_q + IW'(1);
						if (idx_last) begin
							count_q <= '0;
							trunc_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// the size may be lowered mid-frame, so the count is bounded by the store only
	`ASSERT_NEVER(a_count_in_range, clk, arst_n, count_q > CW'(MAX_POINTS))
	`ASSERT_NEVER(a_idx_in_range, clk, arst_n, state_q != r2fft_pkg::ST_IDLE && idx_q >= n7)
	`ASSERT_IMPLY(a_frame_end_clears, clk, arst_n, frame_done |=> (state_q == r2fft_pkg::ST_IDLE && count_q == '0 && !trunc_q))
	`ASSERT_NEVER(a_stage_in_range, clk, arst_n, state_q == r2fft_pkg::ST_BF_RD && (stage_q == 3'd0 || stage_q > lg_act))

endmodule

FILE: sv/radix2_fft_forward_inverse.sv
// top level of the radix-2 forward and inverse fft
// Radix-2 decimation-in-time FFT over frames of up to MAX_POINTS samples.
// Samples are taken one per cycle while the block is idle; the request that
// carries frame_last closes the frame, which is zero padded to
// N = 2^log2_points points (0 acts as 1, values above the largest size that
// fits MAX_POINTS act as that size). Samples beyond N are dropped and the
// frame's results carry truncated. Forward mode transforms real samples;
// inverse mode conjugates, transforms without 1/N scaling and gives real
// parts only, with bin_im held at zero. Twiddles are Q1.14, products round to
// nearest with ties upward, each stage grows one bit and saturates to
// SAMPLE_WIDTH+7 bits. After frame_last the block holds off input through the
// bit-reversed copy, the butterflies in read, multiply, sum and two write steps
// over (N/2)*log2 N butterflies (one shared butterfly unit on a two-read,
// one-write work memory) and a read and a load per result emitted, longer
// when the output side stalls. Configuration must be written only while no
// frame is in flight; the block itself does not enforce this.
module radix2_fft_forward_inverse #(
	parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [0:0]                     cfg_index,
	input  logic [2:0]                     cfg_data,
	// sample requests
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_im,
	input  logic                           frame_last,
	// bin requests
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH+6:0] bin_re,
	output logic signed [SAMPLE_WIDTH+6:0] bin_im,
	output logic [5:0]                     bin_index,
	output logic                           bin_last,
	output logic                           truncated
);

	r2fft_pkg::cmd_t    cmd;
	r2fft_pkg::status_t status;

	// sequencing, frame counters and configuration registers
	r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.frame_last (frame_last),
		.status     (status),
		.cmd        (cmd)
	);

	// memories, butterfly arithmetic and the output register
	r2fft_dp #(.MAX_POINTS(MAX_POINTS), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.sample_re (sample_re),
		.sample_im (sample_im),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_re    (bin_re),
		.bin_im    (bin_im),
		.bin_index (bin_index),
		.bin_last  (bin_last),
		.truncated (truncated)
	);

endmodule
